[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions, clocked on clk and held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/wavp_pkg.sv]
// ----------------------------------------------------------------------------
// WAV header parser package
// Phase and status codes, chunk ids and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wavp_pkg;

    // Parser phases
    localparam logic [3:0] PH_RIFF      = 4'd0;
    localparam logic [3:0] PH_WAVE      = 4'd1;
    localparam logic [3:0] PH_FMT_HDR   = 4'd2;
    localparam logic [3:0] PH_FMT_SKIP  = 4'd3;
    localparam logic [3:0] PH_FMT_BODY  = 4'd4;
    localparam logic [3:0] PH_DATA_HDR  = 4'd5;
    localparam logic [3:0] PH_DATA_SKIP = 4'd6;
    localparam logic [3:0] PH_ACCEPT    = 4'd7;
    localparam logic [3:0] PH_REJECT    = 4'd8;

    // Result status codes
    localparam logic [2:0] ST_PARSING = 3'd0;
    localparam logic [2:0] ST_ACCEPT  = 3'd1;
    localparam logic [2:0] ST_REJECT  = 3'd2;
    localparam logic [2:0] ST_PAYLOAD = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    // Chunk ids as they arrive, first byte in the top lane
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [15:0] TAG_PCM        = 16'h0001;
    localparam logic [15:0] TAG_EXTENSIBLE = 16'hFFFE;
    localparam logic [31:0] FMT_LEN_SHORT  = 32'd16;
    localparam logic [31:0] FMT_LEN_LONG   = 32'd40;
    localparam logic [15:0] BITS_16        = 16'd16;
    localparam logic [15:0] BITS_32        = 16'd32;

    typedef struct packed {
        logic latch;    // capture the input word
        logic step;     // advance the parser by the captured byte
        logic mul;      // register block align times sample rate
        logic check;    // judge the fmt fields
        logic div_end;  // take the divider result
        logic load;     // fill the output register
    } dp_cmd_t;

    typedef struct packed {
        logic need_check;  // the byte closes the fmt chunk
        logic need_div;    // the byte closes a usable data header
        logic div_done;    // divider result is ready
    } dp_stat_t;

endpackage

[src/wavp_if.sv]
// ----------------------------------------------------------------------------
// WAV header parser channels
// Valid/ready channels for the incoming file bytes and the outgoing results.
// ----------------------------------------------------------------------------
interface wavp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       restart;

    modport source (output valid, output data_byte, output end_of_stream,
                    output restart, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream,
                    input restart, output ready);
endinterface

interface wavp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  channels;
    logic [31:0] rate_hz;
    logic [5:0]  sample_width;
    logic [30:0] frame_count;
    logic [7:0]  payload_byte;

    modport source (output valid, output status, output channels, output rate_hz,
                    output sample_width, output frame_count, output payload_byte,
                    input ready);
    modport sink   (input valid, input status, input channels, input rate_hz,
                    input sample_width, input frame_count, input payload_byte,
                    output ready);
endinterface

[src/wavp_div.sv]
// ----------------------------------------------------------------------------
// WAV header parser divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a
// cycle. done pulses for one cycle when quotient and remainder are valid.
// ----------------------------------------------------------------------------
module wavp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);
    localparam int unsigned STEPS = 32;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      quo_reg, quo_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      dsr_reg, dsr_next;
    logic [16:0]      trial;
    logic [16:0]      diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], fits};
            rem_next = fits ? diff[15:0] : trial[15:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

[src/wavp_dp.sv]
// ----------------------------------------------------------------------------
// WAV header parser datapath
// Holds the parse phase, field registers and output register, and advances
// them on commands from the controller.
// ----------------------------------------------------------------------------
module wavp_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  wavp_pkg::dp_cmd_t cmd,
    output wavp_pkg::dp_stat_t stat,
    input  logic [7:0]        data_byte,
    input  logic              end_of_stream,
    input  logic              restart,
    output logic [2:0]        status,
    output logic [2:0]        channels,
    output logic [31:0]       rate_hz,
    output logic [5:0]        sample_width,
    output logic [30:0]       frame_count,
    output logic [7:0]        payload_byte
);
    import wavp_pkg::*;

    // Parser state
    logic [3:0]  phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] tag_reg, tag_next;
    logic [2:0]  chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [30:0] frames_reg, frames_next;
    logic [31:0] prod_reg, prod_next;
    logic [2:0]  res_reg, res_next;

    // Captured input word
    logic [7:0]  byte_reg, byte_next;
    logic        eos_reg, eos_next;
    logic        rst_reg, rst_next;

    // Output register
    logic [2:0]  o_st_reg, o_st_next;
    logic [2:0]  o_chan_reg, o_chan_next;
    logic [31:0] o_rate_reg, o_rate_next;
    logic [5:0]  o_bits_reg, o_bits_next;
    logic [30:0] o_frames_reg, o_frames_next;
    logic [7:0]  o_pay_reg, o_pay_next;

    logic [3:0]  ph;
    logic [5:0]  cnt;
    logic [31:0] id_shift;
    logic [31:0] hdr_len;
    logic [31:0] skip_dec;
    logic [2:0]  st;
    logic        find_data;
    logic        need_check;
    logic        need_div;
    logic [47:0] prod_full;
    logic [15:0] exp_align;
    logic        fmt_ok;
    logic        good;
    logic        div_done;
    logic [31:0] div_quo;
    logic [15:0] div_rem;

    assign prod_full = 48'(align_reg) * 48'(rate_reg);

    always_comb
    begin
        ph         = rst_reg ? PH_RIFF : phase_reg;
        cnt        = rst_reg ? 6'd0 : cnt_reg;
        id_shift   = {id_reg[23:0], byte_reg};
        hdr_len    = {byte_reg, len_reg[23:0]};
        skip_dec   = skip_reg - {31'd0, (skip_reg != 32'd0)};
        find_data  = (ph == PH_DATA_HDR);
        st         = ST_PARSING;
        need_check = 1'b0;
        need_div   = 1'b0;
        exp_align  = (bits_reg == BITS_32) ? {11'd0, chan_reg, 2'b00}
                                           : {12'd0, chan_reg, 1'b0};
        fmt_ok     = ((tag_reg == TAG_PCM) || (tag_reg == TAG_EXTENSIBLE))
                     && (chan_reg != 3'd0)
                     && ((bits_reg == BITS_16) || (bits_reg == BITS_32))
                     && (align_reg == exp_align)
                     && (brate_reg == prod_reg);

        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        skip_next   = skip_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        tag_next    = tag_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        brate_next  = brate_reg;
        align_next  = align_reg;
        bits_next   = bits_reg;
        frames_next = frames_reg;
        res_next    = res_reg;
        prod_next   = cmd.mul ? prod_full[31:0] : prod_reg;
        byte_next   = cmd.latch ? data_byte : byte_reg;
        eos_next    = cmd.latch ? end_of_stream : eos_reg;
        rst_next    = cmd.latch ? restart : rst_reg;

        if (cmd.step)
        begin
            phase_next = ph;
            cnt_next   = cnt;
            unique case (ph)
                PH_RIFF:
                begin
                    if (cnt < 6'd4)
                        id_next = id_shift;
                    if (cnt < 6'd7)
                        cnt_next = cnt + 6'd1;
                    else if (id_reg != ID_RIFF)
                    begin
                        phase_next = PH_REJECT;
                        st         = ST_REJECT;
                    end
                    else
                    begin
                        phase_next = PH_WAVE;
                        cnt_next   = 6'd0;
                    end
                end
                PH_WAVE:
                begin
                    id_next = id_shift;
                    if (cnt < 6'd3)
                        cnt_next = cnt + 6'd1;
                    else if (id_shift != ID_WAVE)
                    begin
                        phase_next = PH_REJECT;
                        st         = ST_REJECT;
                    end
                    else
                    begin
                        phase_next = PH_FMT_HDR;
                        cnt_next   = 6'd0;
                    end
                end
                PH_FMT_HDR, PH_DATA_HDR:
                begin
                    if (cnt < 6'd4)
                        id_next = id_shift;
                    else
                        len_next[8*cnt[1:0] +: 8] = byte_reg;
                    if (cnt < 6'd7)
                        cnt_next = cnt + 6'd1;
                    else
                    begin
                        cnt_next = 6'd0;
                        if (!find_data && (id_reg == ID_FMT))
                        begin
                            if ((hdr_len != FMT_LEN_SHORT) && (hdr_len != FMT_LEN_LONG))
                            begin
                                phase_next = PH_REJECT;
                                st         = ST_REJECT;
                            end
                            else
                            begin
                                tag_next   = '0;
                                chan_next  = '0;
                                rate_next  = '0;
                                brate_next = '0;
                                align_next = '0;
                                bits_next  = '0;
                                phase_next = PH_FMT_BODY;
                            end
                        end
                        else if (find_data && (id_reg == ID_DATA))
                        begin
                            if ((hdr_len == 32'd0) || (align_reg == 16'd0))
                            begin
                                phase_next = PH_REJECT;
                                st         = ST_REJECT;
                            end
                            else
                                need_div = 1'b1;
                        end
                        else
                        begin
                            skip_next = hdr_len;
                            if (hdr_len != 32'd0)
                                phase_next = find_data ? PH_DATA_SKIP : PH_FMT_SKIP;
                        end
                    end
                end
                PH_FMT_SKIP, PH_DATA_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        phase_next = (ph == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
                        cnt_next   = 6'd0;
                    end
                end
                PH_FMT_BODY:
                begin
                    if (cnt < 6'd2)
                        tag_next[8*cnt[0] +: 8] = byte_reg;
                    else if (cnt == 6'd2)
                        id_next = {24'd0, byte_reg};
                    else if (cnt == 6'd3)
                    begin
                        // The raw channel count borrows the id register.
                        id_next = {16'd0, byte_reg, id_reg[7:0]};
                        if ((byte_reg == 8'd0) && (id_reg[7:0] == 8'd1 || id_reg[7:0] == 8'd2
                            || id_reg[7:0] == 8'd4 || id_reg[7:0] == 8'd5
                            || id_reg[7:0] == 8'd6))
                            chan_next = id_reg[2:0];
                        else
                            chan_next = 3'd0;
                    end
                    else if (cnt < 6'd8)
                        rate_next[8*cnt[1:0] +: 8] = byte_reg;
                    else if (cnt < 6'd12)
                        brate_next[8*cnt[1:0] +: 8] = byte_reg;
                    else if (cnt < 6'd14)
                        align_next[8*cnt[0] +: 8] = byte_reg;
                    else if (cnt < 6'd16)
                        bits_next[8*cnt[0] +: 8] = byte_reg;
                    if (({26'd0, cnt} + 32'd1) >= len_reg)
                        need_check = 1'b1;
                    else
                        cnt_next = cnt + 6'd1;
                end
                PH_ACCEPT:
                    st = ST_PAYLOAD;
                default:
                begin
                    phase_next = PH_REJECT;
                    st         = ST_IGNORED;
                end
            endcase
            // A stream that ends while the header is still open is rejected.
            if ((st == ST_PARSING) && eos_reg && !need_check && !need_div)
            begin
                phase_next = PH_REJECT;
                st         = ST_REJECT;
            end
            res_next = st;
        end

        if (cmd.check)
        begin
            if (!fmt_ok)
            begin
                phase_next = PH_REJECT;
                res_next   = ST_REJECT;
            end
            else if (eos_reg)
            begin
                phase_next = PH_REJECT;
                res_next   = ST_REJECT;
            end
            else
            begin
                phase_next = PH_DATA_HDR;
                cnt_next   = 6'd0;
                res_next   = ST_PARSING;
            end
        end

        if (cmd.div_end)
        begin
            if (div_rem != 16'd0)
            begin
                phase_next = PH_REJECT;
                res_next   = ST_REJECT;
            end
            else
            begin
                frames_next = div_quo[30:0];
                phase_next  = PH_ACCEPT;
                res_next    = ST_ACCEPT;
            end
        end

        good          = (res_reg == ST_ACCEPT) || (res_reg == ST_PAYLOAD);
        o_st_next     = cmd.load ? res_reg : o_st_reg;
        o_chan_next   = cmd.load ? (good ? chan_reg : 3'd0) : o_chan_reg;
        o_rate_next   = cmd.load ? (good ? rate_reg : 32'd0) : o_rate_reg;
        o_bits_next   = cmd.load ? (good ? bits_reg[5:0] : 6'd0) : o_bits_reg;
        o_frames_next = cmd.load ? (good ? frames_reg : 31'd0) : o_frames_reg;
        o_pay_next    = cmd.load ? ((res_reg == ST_PAYLOAD) ? byte_reg : 8'd0) : o_pay_reg;
    end

    wavp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.step && need_div),
        .dividend  (hdr_len),
        .divisor   (align_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skip_reg     <= skip_next;
        id_reg       <= id_next;
        len_reg      <= len_next;
        tag_reg      <= tag_next;
        chan_reg     <= chan_next;
        rate_reg     <= rate_next;
        brate_reg    <= brate_next;
        align_reg    <= align_next;
        bits_reg     <= bits_next;
        frames_reg   <= frames_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        byte_reg     <= byte_next;
        eos_reg      <= eos_next;
        rst_reg      <= rst_next;
        o_st_reg     <= o_st_next;
        o_chan_reg   <= o_chan_next;
        o_rate_reg   <= o_rate_next;
        o_bits_reg   <= o_bits_next;
        o_frames_reg <= o_frames_next;
        o_pay_reg    <= o_pay_next;
    end

    assign stat.need_check = need_check;
    assign stat.need_div   = need_div;
    assign stat.div_done   = div_done;

    assign status       = o_st_reg;
    assign channels     = o_chan_reg;
    assign rate_hz      = o_rate_reg;
    assign sample_width = o_bits_reg;
    assign frame_count  = o_frames_reg;
    assign payload_byte = o_pay_reg;
endmodule

[src/wavp_ctrl.sv]
// ----------------------------------------------------------------------------
// WAV header parser controller
// Sequences each input word through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module wavp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output wavp_pkg::dp_cmd_t  cmd,
    input  wavp_pkg::dp_stat_t stat
);
    import wavp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                priority if (stat.need_check)
                    state_next = S_MUL;
                else if (stat.need_div)
                    state_next = S_DIV;
                else
                    state_next = S_OUT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_end = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                // Wait until the previous word has left the output register.
                if (!ovalid_reg || out_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cmd.load)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
endmodule

[src/wav_header_parser_core.sv]
// ----------------------------------------------------------------------------
// WAV header parser core
// Reads a WAV file one byte per word on the stream channel, checks the RIFF,
// WAVE, fmt and data headers and gives one result word per input word on
// the report channel: parsing, accepted (with channel count, sample rate,
// sample width and frame count), rejected, payload byte or ignored.
// A word with restart set begins a new file with that byte.
// Each input word is latched, stepped and then loaded into the output
// register; the last fmt byte also passes the multiply and check steps, and
// the last data header byte waits for the one-bit-a-cycle divider.
// One byte is in flight at a time: a new byte is taken only after the
// last one has been loaded into the output register.
// The next word is taken while the previous result still waits in the
// output register; if the receiver stalls, the new result is held back
// until the register is free, and no further word is taken meanwhile.
// Reset returns the parser to the start of a file with no result pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wav_header_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    wavp_in_if.sink    stream,
    wavp_out_if.source report
);
    import wavp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_take;
    logic     out_good;
    logic     out_other;
    logic     hdr_shown;
    logic     pay_stray;

    wavp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stream.valid),
        .in_ready  (stream.ready),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    wavp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .data_byte     (stream.data_byte),
        .end_of_stream (stream.end_of_stream),
        .restart       (stream.restart),
        .status        (report.status),
        .channels      (report.channels),
        .rate_hz       (report.rate_hz),
        .sample_width  (report.sample_width),
        .frame_count   (report.frame_count),
        .payload_byte  (report.payload_byte)
    );

    assign in_take   = stream.valid && stream.ready;
    assign out_good  = report.valid
                       && ((report.status == ST_ACCEPT) || (report.status == ST_PAYLOAD));
    assign out_other = report.valid && !out_good;
    assign hdr_shown = (report.rate_hz != 32'd0) || (report.frame_count != 31'd0);
    assign pay_stray = report.valid && (report.status != ST_PAYLOAD)
                       && (report.payload_byte != 8'd0);

    `ASSERT_CLK(a_one_word_at_a_time, in_take |=> !stream.ready, "word taken while busy")
    `ASSERT_NEVER(a_accept_has_channels, out_good && (report.channels == 3'd0), "no channels")
    `ASSERT_NEVER(a_fields_zero_otherwise, out_other && hdr_shown, "header fields too early")
    `ASSERT_NEVER(a_payload_only_in_payload, pay_stray, "payload byte outside payload")
endmodule
